/* src/escape_orbit_histogram_core_assert.svh */
// Assertion macros shared by the orbit histogram core
`ifndef ESCAPE_ORBIT_HISTOGRAM_CORE_ASSERT_SVH
`define ESCAPE_ORBIT_HISTOGRAM_CORE_ASSERT_SVH
`ifndef SYNTHESIS
`define EOH_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("%m failed");
`define EOH_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("%m failed");
`else
`define EOH_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define EOH_ASSERT_NXT(lbl, clk, rstn, ante, cons)
`endif
`endif

/* src/eoh_pkg.sv */
// Shared types and constants of the orbit histogram core
package eoh_pkg;

    localparam int FRAC     = 28;
    localparam int MAP_FRAC = 44;

    localparam logic KIND_TRACE = 1'b0;
    localparam logic KIND_READ  = 1'b1;

    localparam logic [2:0] REG_WORLD_MIN_X  = 3'd0;
    localparam logic [2:0] REG_WORLD_MIN_Y  = 3'd1;
    localparam logic [2:0] REG_SCALE_X      = 3'd2;
    localparam logic [2:0] REG_SCALE_Y      = 3'd3;
    localparam logic [2:0] REG_MAX_DEPTH    = 3'd4;
    localparam logic [2:0] REG_IMAGE_WIDTH  = 3'd5;
    localparam logic [2:0] REG_IMAGE_HEIGHT = 3'd6;

    localparam logic [15:0] COUNT_SAT = 16'hFFFF;

    typedef struct packed {
        logic [31:0] world_min_x;
        logic [31:0] world_min_y;
        logic [31:0] scale_x;
        logic [31:0] scale_y;
        logic [15:0] max_depth;
        logic [9:0]  image_width;
        logic [9:0]  image_height;
    } cfg_t;

    typedef enum logic [3:0] {
        ST_CLEAR, ST_IDLE, ST_RDQ, ST_RDD, ST_MUL, ST_ADD, ST_MAP, ST_UV,
        ST_ADR, ST_RD, ST_WR, ST_NXT, ST_FIN, ST_NOESC, ST_DONE
    } state_t;

endpackage

/* src/escape_orbit_histogram_core.sv */
// Top level: escape orbit density histogram with configuration registers
// A trace request iterates until escape or max_depth; an escaping one is then replayed, and
// each replayed point inside the image bumps its texel. One request is in work at a time.
// After reset a clearing pass zeroes all MAX_WIDTH*MAX_HEIGHT histogram entries;
// s_axis_tready stays low during it. Configuration registers reset to their defaults.
module escape_orbit_histogram_core #(
    parameter int MAX_WIDTH  = 512,
    parameter int MAX_HEIGHT = 512,
    parameter int COORD_BITS = 32
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_we,
    input  logic [2:0]          cfg_index,
    input  logic [31:0]         cfg_wdata,
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    input  logic [((2*COORD_BITS+18+7)/8)*8-1:0] s_axis_tdata, // point_re, point_im, texel_index
    input  logic                s_axis_tuser,  // kind
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    output logic [39:0]         m_axis_tdata   // escaped, escape_depth, texel_count
);

    localparam int PW = 2 * COORD_BITS + 18;

    eoh_pkg::cfg_t cfg_reg;
    logic          enable, q_valid, q_kind, pop;
    logic [PW-1:0] q_data;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.world_min_x  <= 32'(-564415880);
            cfg_reg.world_min_y  <= 32'(-332245248);
            cfg_reg.scale_x      <= 32'd10138223;
            cfg_reg.scale_y      <= 32'd13517455;
            cfg_reg.max_depth    <= 16'd1000;
            cfg_reg.image_width  <= 10'd512;
            cfg_reg.image_height <= 10'd512;
        end else if (cfg_we) begin
            case (cfg_index)
                eoh_pkg::REG_WORLD_MIN_X:  cfg_reg.world_min_x  <= cfg_wdata;
                eoh_pkg::REG_WORLD_MIN_Y:  cfg_reg.world_min_y  <= cfg_wdata;
                eoh_pkg::REG_SCALE_X:      cfg_reg.scale_x      <= cfg_wdata;
                eoh_pkg::REG_SCALE_Y:      cfg_reg.scale_y      <= cfg_wdata;
                eoh_pkg::REG_MAX_DEPTH:    cfg_reg.max_depth    <= cfg_wdata[15:0];
                eoh_pkg::REG_IMAGE_WIDTH:  cfg_reg.image_width  <= cfg_wdata[9:0];
                eoh_pkg::REG_IMAGE_HEIGHT: cfg_reg.image_height <= cfg_wdata[9:0];
                default: begin
                end
            endcase
        end
    end

    eoh_front #(
        .PW(PW)
    ) u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .enable        (enable),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_payload     (s_axis_tdata[PW-1:0]),
        .s_kind        (s_axis_tuser),
        .q_valid       (q_valid),
        .q_kind        (q_kind),
        .q_data        (q_data),
        .pop           (pop)
    );

    eoh_engine #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .COORD_BITS (COORD_BITS)
    ) u_engine (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg           (cfg_reg),
        .q_valid       (q_valid),
        .q_kind        (q_kind),
        .q_data        (q_data),
        .pop           (pop),
        .enable        (enable),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

endmodule

/* src/eoh_front.sv */
// Front end: accepts requests, splits off the kind, queues them for the engine
module eoh_front #(
    parameter int PW = 82
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          enable,
    input  logic          s_axis_tvalid,
    output logic          s_axis_tready,
    input  logic [PW-1:0] s_payload,
    input  logic          s_kind,
    output logic          q_valid,
    output logic          q_kind,
    output logic [PW-1:0] q_data,
    input  logic          pop
);

    logic [PW:0] entry_reg [2];
    logic        wr_ptr_reg, wr_ptr_next;
    logic        rd_ptr_reg, rd_ptr_next;
    logic [1:0]  count_reg, count_next;
    logic        push;

    assign s_axis_tready = enable && (count_reg != 2'd2);
    assign push          = s_axis_tvalid && s_axis_tready;
    assign q_valid       = count_reg != 2'd0;
    assign q_kind        = entry_reg[rd_ptr_reg][PW];
    assign q_data        = entry_reg[rd_ptr_reg][PW-1:0];

    always_comb begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= {s_kind, s_payload};
        end
    end

endmodule

/* src/eoh_engine.sv */
// Back end: orbit iteration, texel mapping, histogram memory and result register
`include "escape_orbit_histogram_core_assert.svh"
module eoh_engine #(
    parameter int MAX_WIDTH  = 512,
    parameter int MAX_HEIGHT = 512,
    parameter int COORD_BITS = 32
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  eoh_pkg::cfg_t           cfg,
    input  logic                    q_valid,
    input  logic                    q_kind,
    input  logic [2*COORD_BITS+17:0] q_data,
    output logic                    pop,
    output logic                    enable,
    output logic                    m_axis_tvalid,
    input  logic                    m_axis_tready,
    output logic [39:0]             m_axis_tdata  // escaped, escape_depth, texel_count
);

    localparam int CB     = COORD_BITS;
    localparam int FRAC   = eoh_pkg::FRAC;
    localparam int RW     = FRAC + 3;
    localparam int PW     = 2 * RW;
    localparam int ZW     = (CB > PW + 1 - FRAC ? CB : PW + 1 - FRAC) + 1;
    localparam int DW     = (RW > 32 ? RW : 32) + 2;
    localparam int PXW    = DW + 31;
    localparam int HW     = PXW - eoh_pkg::MAP_FRAC;
    localparam int TEXELS = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW     = TEXELS > 1 ? $clog2(TEXELS) : 1;
    localparam int UW     = $clog2(MAX_WIDTH + 1);
    localparam int VW     = $clog2(MAX_HEIGHT + 1);
    localparam logic signed [PW:0]   FOUR = (PW + 1)'(4) <<< (2 * FRAC);
    localparam logic signed [ZW-1:0] TWO  = ZW'(2) <<< FRAC;

    eoh_pkg::state_t state_reg, state_next;

    logic [15:0]            mem [TEXELS];
    logic [15:0]            rd_data_reg;
    logic                   mem_we;
    logic [AW-1:0]          mem_addr;
    logic [15:0]            mem_wdata;

    logic [AW-1:0]          clr_cnt_reg;
    logic [15:0]            n_reg, esc_n_reg;
    logic                   pass_reg;
    logic signed [CB-1:0]   cr_reg, ci_reg;
    logic [17:0]            tidx_reg;
    logic signed [RW-1:0]   r_reg, i_reg;
    logic signed [PW-1:0]   rr_reg, ii_reg, ri_reg;
    logic [PXW-1:0]         px_reg, py_reg;
    logic                   negx_reg, negy_reg;
    logic [UW-1:0]          u_reg;
    logic [VW-1:0]          v_reg;
    logic [AW-1:0]          idx_reg;
    logic                   res_esc_reg;
    logic [15:0]            res_depth_reg, res_cnt_reg;
    logic                   out_valid_reg;
    logic [39:0]            out_data_reg;

    logic signed [PW:0]     mag2, dsq;
    logic signed [ZW-1:0]   nr, ni;
    logic                   esc_mag, bound_esc, out_free, clr_last;
    logic signed [DW-1:0]   dx, dy;
    logic [DW-2:0]          mx, my;
    logic [UW-1:0]          w_lim;
    logic [VW-1:0]          h_lim;
    logic [HW-1:0]          px_hi, py_hi;
    logic                   okx, oky, uv_ok;

    assign enable        = state_reg != eoh_pkg::ST_CLEAR;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign out_free      = !out_valid_reg || m_axis_tready;
    assign clr_last      = clr_cnt_reg == AW'(TEXELS - 1);

    assign mag2      = {rr_reg[PW-1], rr_reg} + {ii_reg[PW-1], ii_reg};
    assign dsq       = {rr_reg[PW-1], rr_reg} - {ii_reg[PW-1], ii_reg};
    assign esc_mag   = (n_reg != 16'd0) && (mag2 > FOUR);
    assign nr        = ZW'(dsq >>> FRAC) + ZW'(cr_reg);
    assign ni        = ZW'(ri_reg >>> (FRAC - 1)) + ZW'(ci_reg);
    assign bound_esc = (nr > TWO) || (nr < -TWO) || (ni > TWO) || (ni < -TWO);

    assign dx = DW'(r_reg) - DW'($signed(cfg.world_min_x));
    assign dy = DW'(i_reg) - DW'($signed(cfg.world_min_y));
    assign mx = dx[DW-1] ? (DW-1)'(-dx) : (DW-1)'(dx);
    assign my = dy[DW-1] ? (DW-1)'(-dy) : (DW-1)'(dy);

    assign w_lim = (cfg.image_width > MAX_WIDTH) ? UW'(MAX_WIDTH) : UW'(cfg.image_width);
    assign h_lim = (cfg.image_height > MAX_HEIGHT) ? VW'(MAX_HEIGHT) : VW'(cfg.image_height);
    assign px_hi = px_reg[PXW-1:eoh_pkg::MAP_FRAC];
    assign py_hi = py_reg[PXW-1:eoh_pkg::MAP_FRAC];
    assign okx   = negx_reg ? (w_lim != '0 && px_hi == '0) : (px_hi < HW'(w_lim));
    assign oky   = negy_reg ? (h_lim != '0 && py_hi == '0) : (py_hi < HW'(h_lim));
    assign uv_ok = okx && oky;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= eoh_pkg::ST_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        pop        = 1'b0;
        mem_we     = 1'b0;
        mem_addr   = idx_reg;
        mem_wdata  = (rd_data_reg == eoh_pkg::COUNT_SAT) ? rd_data_reg : rd_data_reg + 16'd1;
        case (state_reg)
            eoh_pkg::ST_CLEAR: begin
                mem_we    = 1'b1;
                mem_addr  = clr_cnt_reg;
                mem_wdata = 16'd0;
                if (clr_last) begin
                    state_next = eoh_pkg::ST_IDLE;
                end
            end
            eoh_pkg::ST_IDLE: begin
                if (q_valid) begin
                    pop        = 1'b1;
                    state_next = (q_kind == eoh_pkg::KIND_READ) ? eoh_pkg::ST_RDQ
                                                                : eoh_pkg::ST_MUL;
                end
            end
            eoh_pkg::ST_RDQ: begin
                mem_addr   = AW'(tidx_reg);
                state_next = eoh_pkg::ST_RDD;
            end
            eoh_pkg::ST_RDD: state_next = eoh_pkg::ST_DONE;
            eoh_pkg::ST_MUL: state_next = eoh_pkg::ST_ADD;
            eoh_pkg::ST_ADD: begin
                if (esc_mag) begin
                    state_next = eoh_pkg::ST_FIN;
                end else if (pass_reg && n_reg != 16'd0) begin
                    state_next = eoh_pkg::ST_MAP;
                end else begin
                    state_next = eoh_pkg::ST_NXT;
                end
            end
            eoh_pkg::ST_MAP: state_next = eoh_pkg::ST_UV;
            eoh_pkg::ST_UV:  state_next = uv_ok ? eoh_pkg::ST_ADR : eoh_pkg::ST_NXT;
            eoh_pkg::ST_ADR: state_next = eoh_pkg::ST_RD;
            eoh_pkg::ST_RD:  state_next = eoh_pkg::ST_WR;
            eoh_pkg::ST_WR: begin
                mem_we     = 1'b1;
                state_next = eoh_pkg::ST_NXT;
            end
            eoh_pkg::ST_NXT: begin
                if (n_reg == cfg.max_depth) begin
                    state_next = eoh_pkg::ST_NOESC;
                end else if (bound_esc) begin
                    state_next = eoh_pkg::ST_FIN;
                end else begin
                    state_next = eoh_pkg::ST_MUL;
                end
            end
            eoh_pkg::ST_FIN:   state_next = pass_reg ? eoh_pkg::ST_DONE : eoh_pkg::ST_MUL;
            eoh_pkg::ST_NOESC: state_next = eoh_pkg::ST_DONE;
            eoh_pkg::ST_DONE: begin
                if (out_free) begin
                    state_next = eoh_pkg::ST_IDLE;
                end
            end
            default: state_next = eoh_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_addr] <= mem_wdata;
        end
        rd_data_reg <= mem[mem_addr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_cnt_reg <= '0;
        end else if (state_reg == eoh_pkg::ST_CLEAR) begin
            clr_cnt_reg <= clr_cnt_reg + AW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (state_reg == eoh_pkg::ST_DONE && out_free) begin
            out_valid_reg <= 1'b1;
        end else if (m_axis_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == eoh_pkg::ST_DONE && out_free) begin
            out_data_reg <= {7'd0, res_cnt_reg, res_depth_reg, res_esc_reg};
        end
    end

    always_ff @(posedge aclk) begin
        case (state_reg)
            eoh_pkg::ST_IDLE: begin
                cr_reg   <= $signed(q_data[CB-1:0]);
                ci_reg   <= $signed(q_data[2*CB-1:CB]);
                tidx_reg <= q_data[2*CB+17:2*CB];
                r_reg    <= '0;
                i_reg    <= '0;
                n_reg    <= 16'd0;
                pass_reg <= 1'b0;
            end
            eoh_pkg::ST_RDD: begin
                res_esc_reg   <= 1'b0;
                res_depth_reg <= 16'd0;
                res_cnt_reg   <= (32'(tidx_reg) < 32'(TEXELS)) ? rd_data_reg : 16'd0;
            end
            eoh_pkg::ST_MUL: begin
                rr_reg <= r_reg * r_reg;
                ii_reg <= i_reg * i_reg;
                ri_reg <= r_reg * i_reg;
            end
            eoh_pkg::ST_MAP: begin
                px_reg   <= PXW'(mx) * PXW'(cfg.scale_x);
                py_reg   <= PXW'(my) * PXW'(cfg.scale_y);
                negx_reg <= dx[DW-1];
                negy_reg <= dy[DW-1];
            end
            eoh_pkg::ST_UV: begin
                u_reg <= negx_reg ? '0 : UW'(px_hi);
                v_reg <= negy_reg ? '0 : VW'(py_hi);
            end
            eoh_pkg::ST_ADR: begin
                idx_reg <= AW'(AW'(v_reg) * AW'(w_lim) + AW'(u_reg));
            end
            eoh_pkg::ST_NXT: begin
                n_reg <= n_reg + 16'd1;
                r_reg <= RW'(nr);
                i_reg <= RW'(ni);
            end
            eoh_pkg::ST_FIN: begin
                if (!pass_reg) begin
                    esc_n_reg <= n_reg;
                    pass_reg  <= 1'b1;
                    r_reg     <= '0;
                    i_reg     <= '0;
                    n_reg     <= 16'd0;
                end else begin
                    res_esc_reg   <= 1'b1;
                    res_depth_reg <= esc_n_reg;
                    res_cnt_reg   <= 16'd0;
                end
            end
            eoh_pkg::ST_NOESC: begin
                res_esc_reg   <= 1'b0;
                res_depth_reg <= 16'd0;
                res_cnt_reg   <= 16'd0;
            end
            default: begin
            end
        endcase
    end

    `EOH_ASSERT_IMP(a_no_pop_clear, aclk, aresetn, state_reg == eoh_pkg::ST_CLEAR, !pop)
    `EOH_ASSERT_IMP(a_we_state, aclk, aresetn, mem_we, state_reg == eoh_pkg::ST_WR || state_reg == eoh_pkg::ST_CLEAR)
    `EOH_ASSERT_IMP(a_noesc_pass1, aclk, aresetn, state_reg == eoh_pkg::ST_NOESC, !pass_reg)
    `EOH_ASSERT_NXT(a_pop_leaves, aclk, aresetn, pop, state_reg != eoh_pkg::ST_IDLE)

endmodule
